// File: sv/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg
// Beat types and codes for the strongly connected components block.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_RUN   = 2'd2;
  localparam logic [1:0] KIND_QUERY = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_RUN   = 2'd1;
  localparam logic [1:0] ST_BAD_VERT = 2'd2;

  localparam int RESULT_LIMIT = 64;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] src_vertex;
    logic [5:0] dst_vertex;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] component_total;
    logic [5:0] component_index;
    logic [5:0] member_vertex;
    logic       last;
  } out_beat_t;

endpackage

// File: sv/strongly_connected_components.sv
// ----------------------------------------------------------------------------
// strongly_connected_components
// Adjacency matrix store with a Kosaraju component search and member query.
//
// Input beats add an edge, clear the graph, run the search or query the
// members of one vertex's component. Add, clear and run give one output
// beat each; a query gives one beat per member in second-pass preorder,
// with last on the final one, or one error beat.
// The configuration channel writes vertex_count; it is taken while idle.
// Add edge reads the source row and destination column, then writes both;
// a query reads the component and its info, then each member before its
// beat. A run scans roots, pushes and pops vertices in each pass and
// fetches finish order in pass two; all memory reads are registered.
// Reset empties the graph (per-row valid flags), sets vertex_count to 64
// and marks no run done. A full output register sits at the output: the
// block takes the next input beat while a result waits, and a stalled
// receiver holds the register and pauses the query walk.
// ----------------------------------------------------------------------------
module strongly_connected_components #(
  parameter int MAX_VERTS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  scc_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output scc_pkg::out_beat_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [6:0]         cfg_data_i
);

  localparam int V  = MAX_VERTS;
  localparam int AW = $clog2(MAX_VERTS);
  localparam int CW = $clog2(MAX_VERTS + 1);

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_ADD_WR   = 14'b00000000000010,
    S_P1_ROOT  = 14'b00000000000100,
    S_P2_FETCH = 14'b00000000001000,
    S_P2_ROOT  = 14'b00000000010000,
    S_SRCH_RD  = 14'b00000000100000,
    S_SRCH_EV  = 14'b00000001000000,
    S_POP_WAIT = 14'b00000010000000,
    S_Q_COMP   = 14'b00000100000000,
    S_Q_INFO   = 14'b00001000000000,
    S_Q_RD     = 14'b00010000000000,
    S_Q_OUT    = 14'b00100000000000,
    S_RESP     = 14'b01000000000000,
    S_CLEAR    = 14'b10000000000000
  } state_e;

  typedef struct packed {
    logic [AW-1:0] start;
    logic [CW-1:0] size;
  } info_t;

  state_e state_q, state_d;

  logic [V-1:0]  rows_mem [V];
  logic [V-1:0]  cols_mem [V];
  logic [AW-1:0] stack_mem [V];
  logic [AW-1:0] fin_mem [V];
  logic [AW-1:0] comp_mem [V];
  logic [AW-1:0] pre_mem [V];
  info_t         info_mem [V];

  logic [V-1:0] row_ok_q, row_ok_d, col_ok_q, col_ok_d;
  logic [V-1:0] vis_q, vis_d;
  logic [V-1:0] row_rd_q, col_rd_q;
  logic         row_okr_q, col_okr_q;
  logic [AW-1:0] stack_rd_q, fin_rd_q, comp_rd_q, pre_rd_q;
  info_t         info_rd_q;

  logic [6:0]    vc_q, vc_d;
  logic          ready_q, ready_d;
  logic [CW-1:0] total_q, total_d;
  logic [1:0]    resp_q, resp_d;
  logic          pass2_q, pass2_d;
  logic [CW-1:0] sp_q, sp_d, fin_q, fin_d, pre_q, pre_d, comps_q, comps_d;
  logic [CW-1:0] r_q, r_d, k_q, k_d, tstart_q, tstart_d, lim_q, lim_d;
  logic [AW-1:0] top_q, top_d, src_q, src_d, dst_q, dst_d;
  logic [AW-1:0] comp_q, comp_d, qstart_q, qstart_d;

  logic               out_valid_q, out_valid_d;
  scc_pkg::out_beat_t out_q, out_d;

  logic [CW-1:0] n_act;
  logic [V-1:0]  nmask, adj, cand;
  logic          cand_any;
  logic [AW-1:0] cand_idx;
  logic          out_free, in_acc, src_ok, dst_ok;

  logic          row_re, col_re;
  logic [AW-1:0] row_ra, col_ra;
  logic          adj_we;
  logic [V-1:0]  row_wd, col_wd;
  logic          stk_we, stk_re, fin_we, fin_re, cmp_we, cmp_re, pre_we, pre_re;
  logic          inf_we, inf_re;
  logic [AW-1:0] stk_wa, stk_ra, stk_wd, fin_wa, fin_ra, fin_wd;
  logic [AW-1:0] cmp_wa, cmp_ra, cmp_wd, pre_wa, pre_ra, pre_wd, inf_wa, inf_ra;
  info_t         inf_wd;

  function automatic logic [AW-1:0] first_set(input logic [V-1:0] c);
    logic [AW-1:0] idx;
    idx = '0;
    for (int i = V - 1; i >= 0; i--) begin
      if (c[i]) idx = AW'(i);
    end
    return idx;
  endfunction

  always_comb begin
    if (vc_q == 7'd0) n_act = CW'(1);
    else if (32'(vc_q) > MAX_VERTS) n_act = CW'(MAX_VERTS);
    else n_act = CW'(vc_q);
  end

  always_comb begin
    for (int i = 0; i < V; i++) nmask[i] = (i < 32'(n_act));
  end

  assign adj      = pass2_q ? (row_okr_q ? row_rd_q : '0) : (col_okr_q ? col_rd_q : '0);
  assign cand     = adj & ~vis_q & nmask;
  assign cand_any = |cand;
  assign cand_idx = first_set(cand);

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE) || cfg_valid_i;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign src_ok      = 32'(in_data_i.src_vertex) < 32'(n_act);
  assign dst_ok      = 32'(in_data_i.dst_vertex) < 32'(n_act);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q;
    row_ok_d = row_ok_q;  col_ok_d = col_ok_q;  vis_d = vis_q;
    vc_d = vc_q;  ready_d = ready_q;  total_d = total_q;  resp_d = resp_q;
    pass2_d = pass2_q;  sp_d = sp_q;  fin_d = fin_q;  pre_d = pre_q;
    comps_d = comps_q;  r_d = r_q;  k_d = k_q;  tstart_d = tstart_q;
    lim_d = lim_q;  top_d = top_q;  src_d = src_q;  dst_d = dst_q;
    comp_d = comp_q;  qstart_d = qstart_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d = out_q;
    row_re = 1'b0;  col_re = 1'b0;  row_ra = top_q;  col_ra = top_q;
    adj_we = 1'b0;
    row_wd = (row_okr_q ? row_rd_q : '0) | (V'(1) << dst_q);
    col_wd = (col_okr_q ? col_rd_q : '0) | (V'(1) << src_q);
    stk_we = 1'b0;  stk_re = 1'b0;  stk_wa = '0;  stk_ra = '0;  stk_wd = '0;
    fin_we = 1'b0;  fin_re = 1'b0;  fin_wa = AW'(fin_q);  fin_ra = '0;  fin_wd = top_q;
    cmp_we = 1'b0;  cmp_re = 1'b0;  cmp_wa = '0;  cmp_ra = src_q;
    cmp_wd = AW'(comps_q);
    pre_we = 1'b0;  pre_re = 1'b0;  pre_wa = AW'(pre_q);  pre_wd = '0;
    pre_ra = AW'(CW'(qstart_q) + k_q);
    inf_we = 1'b0;  inf_re = 1'b0;  inf_wa = AW'(comps_q);  inf_ra = comp_rd_q;
    inf_wd = '{start: AW'(tstart_q), size: pre_q - tstart_q};

    unique case (state_q)
      S_IDLE: begin
        if (cfg_valid_i) begin
          vc_d = cfg_data_i;
          ready_d = 1'b0;
          total_d = '0;
        end else if (in_acc) begin
          src_d = AW'(in_data_i.src_vertex);
          dst_d = AW'(in_data_i.dst_vertex);
          resp_d = scc_pkg::ST_OK;
          unique case (in_data_i.kind)
            scc_pkg::KIND_ADD: begin
              if (src_ok && dst_ok) begin
                row_re = 1'b1;  row_ra = AW'(in_data_i.src_vertex);
                col_re = 1'b1;  col_ra = AW'(in_data_i.dst_vertex);
                state_d = S_ADD_WR;
              end else begin
                resp_d = scc_pkg::ST_BAD_VERT;
                state_d = S_RESP;
              end
            end
            scc_pkg::KIND_CLEAR: state_d = S_CLEAR;
            scc_pkg::KIND_RUN: begin
              vis_d = '0;  fin_d = '0;  r_d = '0;  pass2_d = 1'b0;
              state_d = S_P1_ROOT;
            end
            scc_pkg::KIND_QUERY: begin
              if (!ready_q) begin
                resp_d = scc_pkg::ST_NO_RUN;
                state_d = S_RESP;
              end else if (!src_ok) begin
                resp_d = scc_pkg::ST_BAD_VERT;
                state_d = S_RESP;
              end else begin
                cmp_re = 1'b1;  cmp_ra = AW'(in_data_i.src_vertex);
                state_d = S_Q_COMP;
              end
            end
            default: state_d = S_RESP;
          endcase
        end
      end
      S_ADD_WR: begin
        adj_we = 1'b1;
        row_ok_d[src_q] = 1'b1;
        col_ok_d[dst_q] = 1'b1;
        ready_d = 1'b0;  total_d = '0;
        state_d = S_RESP;
      end
      S_CLEAR: begin
        row_ok_d = '0;  col_ok_d = '0;
        ready_d = 1'b0;  total_d = '0;
        state_d = S_RESP;
      end
      S_P1_ROOT: begin
        r_d = r_q + CW'(1);
        if (r_q == n_act) begin
          vis_d = '0;  pre_d = '0;  comps_d = '0;  k_d = n_act;  pass2_d = 1'b1;
          state_d = S_P2_FETCH;
        end else if (!vis_q[AW'(r_q)]) begin
          vis_d[AW'(r_q)] = 1'b1;
          stk_we = 1'b1;  stk_wa = '0;  stk_wd = AW'(r_q);
          sp_d = CW'(1);  top_d = AW'(r_q);
          state_d = S_SRCH_RD;
        end
      end
      S_P2_FETCH: begin
        if (k_q == '0) begin
          total_d = comps_q;  ready_d = 1'b1;
          state_d = S_RESP;
        end else begin
          fin_re = 1'b1;  fin_ra = AW'(k_q - CW'(1));
          state_d = S_P2_ROOT;
        end
      end
      S_P2_ROOT: begin
        k_d = k_q - CW'(1);
        if (!vis_q[fin_rd_q]) begin
          vis_d[fin_rd_q] = 1'b1;
          stk_we = 1'b1;  stk_wa = '0;  stk_wd = fin_rd_q;
          sp_d = CW'(1);  top_d = fin_rd_q;
          pre_we = 1'b1;  pre_wd = fin_rd_q;
          cmp_we = 1'b1;  cmp_wa = fin_rd_q;
          tstart_d = pre_q;  pre_d = pre_q + CW'(1);
          state_d = S_SRCH_RD;
        end else begin
          state_d = S_P2_FETCH;
        end
      end
      S_SRCH_RD: begin
        row_re = 1'b1;  col_re = 1'b1;
        state_d = S_SRCH_EV;
      end
      S_SRCH_EV: begin
        if (cand_any) begin
          vis_d[cand_idx] = 1'b1;
          stk_we = 1'b1;  stk_wa = AW'(sp_q);  stk_wd = cand_idx;
          sp_d = sp_q + CW'(1);  top_d = cand_idx;
          if (pass2_q) begin
            pre_we = 1'b1;  pre_wd = cand_idx;
            cmp_we = 1'b1;  cmp_wa = cand_idx;
            pre_d = pre_q + CW'(1);
          end
          state_d = S_SRCH_RD;
        end else begin
          if (!pass2_q) begin
            fin_we = 1'b1;
            fin_d = fin_q + CW'(1);
          end
          sp_d = sp_q - CW'(1);
          if (sp_q == CW'(1)) begin
            if (pass2_q) begin
              inf_we = 1'b1;
              comps_d = comps_q + CW'(1);
              state_d = S_P2_FETCH;
            end else begin
              state_d = S_P1_ROOT;
            end
          end else begin
            stk_re = 1'b1;  stk_ra = AW'(sp_q - CW'(2));
            state_d = S_POP_WAIT;
          end
        end
      end
      S_POP_WAIT: begin
        top_d = stack_rd_q;
        state_d = S_SRCH_RD;
      end
      S_Q_COMP: begin
        comp_d = comp_rd_q;
        inf_re = 1'b1;
        state_d = S_Q_INFO;
      end
      S_Q_INFO: begin
        qstart_d = info_rd_q.start;
        if (32'(info_rd_q.size) > scc_pkg::RESULT_LIMIT) lim_d = CW'(scc_pkg::RESULT_LIMIT);
        else lim_d = info_rd_q.size;
        k_d = '0;
        state_d = S_Q_RD;
      end
      S_Q_RD: begin
        pre_re = 1'b1;
        state_d = S_Q_OUT;
      end
      S_Q_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{status: scc_pkg::ST_OK, component_total: 7'(total_q),
                    component_index: 6'(comp_q), member_vertex: 6'(pre_rd_q),
                    last: (k_q + CW'(1) == lim_q)};
          k_d = k_q + CW'(1);
          state_d = (k_q + CW'(1) == lim_q) ? S_IDLE : S_Q_RD;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{status: resp_q, component_total: 7'(total_q),
                    component_index: '0, member_vertex: '0, last: 1'b1};
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      row_ok_q <= '0;  col_ok_q <= '0;  vis_q <= '0;
      vc_q <= 7'd64;  ready_q <= 1'b0;  total_q <= '0;  resp_q <= scc_pkg::ST_OK;
      pass2_q <= 1'b0;  sp_q <= '0;  fin_q <= '0;  pre_q <= '0;  comps_q <= '0;
      r_q <= '0;  k_q <= '0;  tstart_q <= '0;  lim_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      row_ok_q <= row_ok_d;  col_ok_q <= col_ok_d;  vis_q <= vis_d;
      vc_q <= vc_d;  ready_q <= ready_d;  total_q <= total_d;  resp_q <= resp_d;
      pass2_q <= pass2_d;  sp_q <= sp_d;  fin_q <= fin_d;  pre_q <= pre_d;
      comps_q <= comps_d;  r_q <= r_d;  k_q <= k_d;  tstart_q <= tstart_d;
      lim_q <= lim_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;  src_q <= src_d;  dst_q <= dst_d;
    comp_q <= comp_d;  qstart_q <= qstart_d;  out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (adj_we) rows_mem[src_q] <= row_wd;
    if (row_re) begin
      row_rd_q  <= rows_mem[row_ra];
      row_okr_q <= row_ok_q[row_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adj_we) cols_mem[dst_q] <= col_wd;
    if (col_re) begin
      col_rd_q  <= cols_mem[col_ra];
      col_okr_q <= col_ok_q[col_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stack_mem[stk_wa] <= stk_wd;
    if (stk_re) stack_rd_q <= stack_mem[stk_ra];
  end

  always_ff @(posedge clk_i) begin
    if (fin_we) fin_mem[fin_wa] <= fin_wd;
    if (fin_re) fin_rd_q <= fin_mem[fin_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmp_we) comp_mem[cmp_wa] <= cmp_wd;
    if (cmp_re) comp_rd_q <= comp_mem[cmp_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pre_we) pre_mem[pre_wa] <= pre_wd;
    if (pre_re) pre_rd_q <= pre_mem[pre_ra];
  end

  always_ff @(posedge clk_i) begin
    if (inf_we) info_mem[inf_wa] <= inf_wd;
    if (inf_re) info_rd_q <= info_mem[inf_ra];
  end

endmodule
